/* hw/rtl/drse_pkg.sv */
// Package for the disjoint range set engine: command codes, transaction structs,
// sequencer states and table sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package drse_pkg;
   localparam int unsigned MAX_RANGES = 64;
   localparam int unsigned IDX_W = $clog2(MAX_RANGES);
   localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

   typedef enum logic [3:0] {
      CMD_ADD_VALUE = 4'd0, CMD_ADD_RANGE = 4'd1, CMD_REMOVE = 4'd2, CMD_TEST = 4'd3,
      CMD_FIRST = 4'd4, CMD_LAST = 4'd5, CMD_NEXT = 4'd6, CMD_PREV = 4'd7,
      CMD_PREV_MISSING = 4'd8
   } cmd_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   localparam logic [1:0] FM_WRITE = 2'd0;
   localparam logic [1:0] FM_SPLIT = 2'd1;
   localparam logic [1:0] FM_SKIP  = 2'd3;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [31:0] value;
      logic [31:0] range_end;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] answer;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_SCAN_WAIT, S_DEC, S_MOVE_RD, S_MOVE_WR, S_FINAL, S_DONE
   } state_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [31:0]       wlo;
      logic [31:0]       whi;
      logic [IDX_W-1:0]  raddr;
   } mem_ctl_type;
endpackage
`default_nettype wire

/* hw/rtl/drse_table.sv */
// Range table: one synchronous memory holding low and high ends per entry.
// Depends on drse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drse_table (
   input  wire                       clock,
   input  drse_pkg::mem_ctl_type     ctl,
   output logic [31:0]               rd_lo,
   output logic [31:0]               rd_hi
);
   import drse_pkg::*;
   logic [63:0] mem [MAX_RANGES];
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= {ctl.wlo, ctl.whi};
      end
      {rd_lo, rd_hi} <= mem[ctl.raddr];
   end
endmodule
`default_nettype wire

/* hw/rtl/disjoint_range_set_engine.sv */
// Top level of the disjoint range set engine: command sequencer around drse_table.
// Depends on drse_pkg and drse_table.
//
//  channel | ports                       | handshake
//  req     | start, busy, req_payload    | accepted when start && !busy
//  rsp     | rsp_valid, rsp_payload      | one-cycle strobe, no back-pressure
//
// Sequence: a command scans the table one entry at a time (S_SCAN issues the read,
// S_SCAN_WAIT sees the data), then shifts entries for an insert, merge, split or removal
// one entry at a time (S_MOVE_RD, S_MOVE_WR) and writes the new entry in S_FINAL before
// S_DONE raises the response strobe; all of it goes through the one table memory.
// Reset: clears the entry count and the sequencer; the table needs no clearing.
// Stalls: busy stays high from acceptance until the response strobe cycle, in which
// the next transaction may already be accepted.
`timescale 1ns / 1ps
`default_nettype none
module disjoint_range_set_engine (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  drse_pkg::req_type      req_payload,
   output logic                   rsp_valid,
   output drse_pkg::rsp_type      rsp_payload
);
   import drse_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;       // scan index
   logic [CNT_W-1:0] i_ff, i_in;           // first touched entry
   logic [CNT_W-1:0] j_ff, j_in;           // end of absorbed run
   logic             i_set_ff, i_set_in;
   logic             hit_ff, hit_in;
   logic [31:0]      lo_ff, lo_in, hi_ff, hi_in;     // merged range or holder
   logic [CNT_W-1:0] src_ff, src_in, dst_ff, dst_in, stop_ff, stop_in;
   logic             dir_up_ff, dir_up_in;           // shift toward higher index
   logic [3:0]       cmd_ff;
   logic [31:0]      v_ff, e_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rv_ff, rv_in;
   logic [1:0]       fmode_ff, fmode_in;   // final write kind
   mem_ctl_type      ctl;
   logic [31:0]      rd_lo, rd_hi;

   drse_table u_table (.clock(clock), .ctl(ctl), .rd_lo(rd_lo), .rd_hi(rd_hi));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      if (state_ff == S_IDLE && start) begin
         cmd_ff <= req_payload.cmd;
         v_ff   <= req_payload.value;
         e_ff   <= (req_payload.cmd == CMD_ADD_VALUE) ? req_payload.value
                                                       : req_payload.range_end;
      end
      idx_ff <= idx_in; i_ff <= i_in; j_ff <= j_in; i_set_ff <= i_set_in;
      hit_ff <= hit_in; lo_ff <= lo_in; hi_ff <= hi_in;
      src_ff <= src_in; dst_ff <= dst_in; stop_ff <= stop_in; dir_up_ff <= dir_up_in;
      rsp_ff <= rsp_in; fmode_ff <= fmode_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rv_ff;
   assign rsp_payload = rsp_ff;

   logic [31:0] vm1;
   assign vm1 = v_ff - 32'd1;

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; i_in = i_ff;
      j_in = j_ff; i_set_in = i_set_ff; hit_in = hit_ff; lo_in = lo_ff; hi_in = hi_ff;
      src_in = src_ff; dst_in = dst_ff; stop_in = stop_ff;
      dir_up_in = dir_up_ff; rsp_in = rsp_ff;
      rv_in = 1'b0; fmode_in = fmode_ff;
      ctl = '0;
      ctl.raddr = idx_ff[IDX_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in = '0; i_set_in = 1'b0; hit_in = 1'b0; j_in = '0; i_in = '0;
               rsp_in = '0;
               lo_in = req_payload.value;
               hi_in = (req_payload.cmd == CMD_ADD_VALUE) ? req_payload.value
                                                          : req_payload.range_end;
               if (req_payload.cmd == CMD_LAST) idx_in = count_ff - 1'b1;
               state_in = S_SCAN;
               if (req_payload.cmd == CMD_ADD_RANGE &&
                   req_payload.value > req_payload.range_end) begin
                  rsp_in.status = ST_INVALID;
                  state_in = S_DONE;
               end else if (req_payload.cmd > CMD_PREV_MISSING) begin
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  // empty table: only inserts go on to S_DEC; prev missing answers value - 1 here
                  if (req_payload.cmd == CMD_PREV_MISSING && req_payload.value != 0) begin
                     rsp_in.found = 1'b1; rsp_in.answer = req_payload.value - 32'd1;
                  end
                  if (req_payload.cmd == CMD_ADD_VALUE || req_payload.cmd == CMD_ADD_RANGE)
                     state_in = S_DEC;
                  else state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            ctl.raddr = idx_ff[IDX_W-1:0];
            state_in = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: begin
            // rd_lo/rd_hi hold entry idx_ff
            state_in = S_SCAN;
            idx_in = idx_ff + 1'b1;
            case (cmd_ff)
               CMD_ADD_VALUE, CMD_ADD_RANGE: begin
                  if ({1'b0, rd_hi} + 33'd1 < {1'b0, v_ff}) begin
                     i_in = idx_ff + 1'b1; j_in = idx_ff + 1'b1;
                  end else if ({1'b0, rd_lo} <= {1'b0, e_ff} + 33'd1) begin
                     if (!i_set_ff) begin
                        i_set_in = 1'b1;
                        if (rd_lo < lo_ff) lo_in = rd_lo;
                     end
                     if (rd_hi > hi_ff) hi_in = rd_hi;
                     j_in = idx_ff + 1'b1;
                  end else state_in = S_DEC;
               end
               CMD_REMOVE, CMD_TEST: begin
                  if (rd_lo <= v_ff && v_ff <= rd_hi) begin
                     hit_in = 1'b1; i_in = idx_ff; lo_in = rd_lo; hi_in = rd_hi;
                     state_in = S_DEC;
                  end
               end
               CMD_FIRST, CMD_LAST: begin
                  rsp_in.found = 1'b1;
                  rsp_in.answer = (cmd_ff == CMD_FIRST) ? rd_lo : rd_hi;
                  state_in = S_DONE;
               end
               CMD_NEXT: begin
                  if (rd_lo > v_ff) begin
                     rsp_in.found = 1'b1; rsp_in.answer = rd_lo; state_in = S_DONE;
                  end else if (rd_hi > v_ff) begin
                     rsp_in.found = 1'b1; rsp_in.answer = v_ff + 32'd1; state_in = S_DONE;
                  end
               end
               CMD_PREV: begin
                  // forward scan: keep the answer from the last entry that qualifies
                  if (rd_lo < v_ff) begin
                     rsp_in.found = 1'b1;
                     rsp_in.answer = (rd_hi < v_ff) ? rd_hi : vm1;
                  end
               end
               default: begin // prev missing
                  if (rd_lo <= vm1 && vm1 <= rd_hi) begin
                     hit_in = 1'b1; lo_in = rd_lo; state_in = S_DEC;
                  end
               end
            endcase
            if (state_in == S_SCAN && idx_ff + 1'b1 >= count_ff) state_in = S_DEC;
         end
         S_DEC: begin
            state_in = S_DONE;
            case (cmd_ff)
               CMD_ADD_VALUE, CMD_ADD_RANGE: begin
                  if (j_ff == i_ff) begin
                     if (count_ff >= CNT_W'(MAX_RANGES)) rsp_in.status = ST_FULL;
                     else begin
                        count_in = count_ff + 1'b1;
                        fmode_in = FM_WRITE;
                        dir_up_in = 1'b1; src_in = count_ff - 1'b1; dst_in = count_ff;
                        stop_in = i_ff;
                        state_in = (count_ff > i_ff) ? S_MOVE_RD : S_FINAL;
                     end
                  end else begin
                     count_in = count_ff - (j_ff - i_ff) + 1'b1;
                     fmode_in = FM_WRITE;
                     dir_up_in = 1'b0; src_in = j_ff; dst_in = i_ff + 1'b1;
                     stop_in = count_ff;
                     state_in = (j_ff - i_ff > 1 && j_ff < count_ff) ? S_MOVE_RD : S_FINAL;
                  end
               end
               CMD_REMOVE: begin
                  if (hit_ff) begin
                     if (lo_ff == v_ff && hi_ff == v_ff) begin
                        count_in = count_ff - 1'b1;
                        dir_up_in = 1'b0; src_in = i_ff + 1'b1; dst_in = i_ff;
                        stop_in = count_ff; fmode_in = FM_SKIP;
                        state_in = (i_ff + 1'b1 < count_ff) ? S_MOVE_RD : S_DONE;
                     end else if (lo_ff == v_ff) begin
                        lo_in = v_ff + 32'd1; fmode_in = FM_WRITE; state_in = S_FINAL;
                     end else if (hi_ff == v_ff) begin
                        hi_in = vm1; fmode_in = FM_WRITE; state_in = S_FINAL;
                     end else if (count_ff >= CNT_W'(MAX_RANGES)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        dir_up_in = 1'b1; src_in = count_ff - 1'b1; dst_in = count_ff;
                        stop_in = i_ff + 1'b1; fmode_in = FM_SPLIT;
                        state_in = (count_ff > i_ff + 1'b1) ? S_MOVE_RD : S_FINAL;
                     end
                  end
               end
               CMD_TEST: rsp_in.found = hit_ff;
               CMD_PREV_MISSING: begin
                  if (v_ff != 0) begin
                     if (!hit_ff) begin
                        rsp_in.found = 1'b1; rsp_in.answer = vm1;
                     end else if (lo_ff != 0) begin
                        rsp_in.found = 1'b1; rsp_in.answer = lo_ff - 32'd1;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_MOVE_RD: begin
            ctl.raddr = src_ff[IDX_W-1:0];
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            ctl.we = 1'b1; ctl.waddr = dst_ff[IDX_W-1:0];
            ctl.wlo = rd_lo; ctl.whi = rd_hi;
            if (dir_up_ff) begin
               src_in = src_ff - 1'b1; dst_in = dst_ff - 1'b1;
               state_in = (src_ff == stop_ff) ? S_FINAL : S_MOVE_RD;
            end else begin
               src_in = src_ff + 1'b1; dst_in = dst_ff + 1'b1;
               state_in = (src_ff + 1'b1 >= stop_ff) ? S_FINAL : S_MOVE_RD;
            end
            if (state_in == S_FINAL && fmode_ff == FM_SKIP) state_in = S_DONE;
         end
         S_FINAL: begin
            ctl.we = 1'b1;
            if (fmode_ff == FM_SPLIT) begin
               // split: upper piece goes above the holder, holder keeps the lower part
               ctl.waddr = IDX_W'(i_ff + 1'b1); ctl.wlo = v_ff + 32'd1; ctl.whi = hi_ff;
               hi_in = vm1; fmode_in = FM_WRITE;
               state_in = S_FINAL;
            end else begin
               ctl.waddr = i_ff[IDX_W-1:0]; ctl.wlo = lo_ff; ctl.whi = hi_ff;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(MAX_RANGES))
      else $error("entry count above table size");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !$past(rsp_valid))
      else $error("back-to-back response strobes");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> busy)
      else $error("accepted transaction without busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status != 2'd3))
      else $error("undefined status code");
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for disjoint_range_set_engine: a scoreboard class predicts
// each command's response from its own copy of the range table and checks every strobe.
// Depends on drse_pkg and the engine RTL.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import drse_pkg::*;

   class range_set_scoreboard;
      bit [31:0] lo_q[$];
      bit [31:0] hi_q[$];
      rsp_type   answer_q[$];
      int        mismatches;

      function int holder(bit [31:0] v);
         for (int i = 0; i < lo_q.size(); i++)
            if (lo_q[i] <= v && v <= hi_q[i]) return i;
         return -1;
      endfunction

      function logic [1:0] merge(bit [31:0] lo, bit [31:0] hi);
         int i;
         int j;
         bit [31:0] nlo;
         bit [31:0] nhi;
         i = 0;
         nlo = lo;
         nhi = hi;
         while (i < lo_q.size() && {1'b0, hi_q[i]} + 33'd1 < {1'b0, lo}) i++;
         j = i;
         while (j < lo_q.size() && {1'b0, lo_q[j]} <= {1'b0, hi} + 33'd1) j++;
         if (j == i) begin
            if (lo_q.size() >= MAX_RANGES) return ST_FULL;
            lo_q.insert(i, lo);
            hi_q.insert(i, hi);
            return ST_OK;
         end
         if (lo_q[i] < nlo) nlo = lo_q[i];
         if (hi_q[j-1] > nhi) nhi = hi_q[j-1];
         for (int k = i; k < j; k++) begin
            lo_q.delete(i);
            hi_q.delete(i);
         end
         lo_q.insert(i, nlo);
         hi_q.insert(i, nhi);
         return ST_OK;
      endfunction

      function logic [1:0] drop(bit [31:0] v);
         int i;
         i = holder(v);
         if (i < 0) return ST_OK;
         if (lo_q[i] == v && hi_q[i] == v) begin
            lo_q.delete(i);
            hi_q.delete(i);
         end else if (lo_q[i] == v) lo_q[i] = v + 1;
         else if (hi_q[i] == v) hi_q[i] = v - 1;
         else begin
            if (lo_q.size() >= MAX_RANGES) return ST_FULL;
            lo_q.insert(i + 1, v + 1);
            hi_q.insert(i + 1, hi_q[i]);
            hi_q[i] = v - 1;
         end
         return ST_OK;
      endfunction

      function void note_request(req_type r);
         rsp_type p;
         int n;
         int h;
         p = '0;
         n = lo_q.size();
         case (r.cmd)
            CMD_ADD_VALUE: p.status = merge(r.value, r.value);
            CMD_ADD_RANGE: p.status = (r.value > r.range_end) ? ST_INVALID
                                      : merge(r.value, r.range_end);
            CMD_REMOVE: p.status = drop(r.value);
            CMD_TEST: p.found = holder(r.value) >= 0;
            CMD_FIRST: if (n > 0) begin p.found = 1; p.answer = lo_q[0]; end
            CMD_LAST: if (n > 0) begin p.found = 1; p.answer = hi_q[n-1]; end
            CMD_NEXT: begin
               for (int i = 0; i < n; i++) begin
                  if (lo_q[i] > r.value) begin p.found = 1; p.answer = lo_q[i]; break; end
                  if (hi_q[i] > r.value) begin p.found = 1; p.answer = r.value + 1; break; end
               end
            end
            CMD_PREV: begin
               for (int i = n - 1; i >= 0; i--) begin
                  if (hi_q[i] < r.value) begin p.found = 1; p.answer = hi_q[i]; break; end
                  if (lo_q[i] < r.value) begin p.found = 1; p.answer = r.value - 1; break; end
               end
            end
            CMD_PREV_MISSING: begin
               if (r.value != 0) begin
                  h = holder(r.value - 1);
                  if (h < 0) begin p.found = 1; p.answer = r.value - 1; end
                  else if (lo_q[h] != 0) begin p.found = 1; p.answer = lo_q[h] - 1; end
               end
            end
            default: ;
         endcase
         answer_q.push_back(p);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         exp = answer_q.pop_front();
         if (got.found !== exp.found || got.answer !== exp.answer
             || got.status !== exp.status) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, actual %p", exp, got);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;
   range_set_scoreboard board = new();

   disjoint_range_set_engine i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_response(rsp_payload);
   end

   task automatic send(logic [3:0] cmd, bit [31:0] v, bit [31:0] e);
      req_payload <= '{cmd: cmd, value: v, range_end: e};
      start <= 1;
      do @(posedge clock); while (busy);
      board.note_request(req_payload);
      @(negedge clock);
      start = 0;
   endtask

   function automatic bit [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         2: return $urandom;
         default: return $urandom_range(0, 300);
      endcase
   endfunction

   task automatic random_item(int full_bias);
      logic [3:0] cmd;
      bit [31:0] v;
      bit [31:0] e;
      v = pick_value();
      e = v + $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) e = pick_value();
      if ($urandom_range(0, 40) == 0) cmd = $urandom_range(9, 15);
      else if (full_bias && $urandom_range(0, 1)) cmd = CMD_ADD_VALUE;
      else cmd = $urandom_range(CMD_ADD_VALUE, CMD_PREV_MISSING);
      if (full_bias && cmd == CMD_ADD_VALUE) v = $urandom_range(0, 400) * 2;
      send(cmd, v, e);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send(CMD_FIRST, 0, 0);
      send(CMD_LAST, 0, 0);
      send(CMD_NEXT, 5, 0);
      send(CMD_PREV, 5, 0);
      send(CMD_PREV_MISSING, 0, 0);
      send(CMD_ADD_RANGE, 10, 5);
      send(CMD_ADD_RANGE, 0, 3);
      send(CMD_PREV_MISSING, 2, 0);
      send(CMD_ADD_VALUE, 32'hFFFF_FFFF, 0);
      send(CMD_NEXT, 32'hFFFF_FFFF, 0);
      send(CMD_PREV, 0, 0);
      send(CMD_ADD_VALUE, 5, 0);
      send(CMD_ADD_VALUE, 4, 0);
      send(CMD_ADD_RANGE, 2, 6);
      send(CMD_REMOVE, 3, 0);
      send(CMD_REMOVE, 100, 0);
      send(CMD_TEST, 3, 0);
      send(CMD_TEST, 4, 0);
      send(CMD_NEXT, 3, 0);
      send(CMD_PREV, 32'hFFFF_FFFF, 0);
      send(CMD_PREV_MISSING, 32'hFFFF_FFFF, 0);
      send(CMD_ADD_RANGE, 0, 32'hFFFF_FFFF);
      send(CMD_REMOVE, 32'h8000_0000, 0);
      send(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_ADD_RANGE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      for (int n = 0; n < 1500;) begin
         int burst;
         burst = $urandom_range(1, 30);
         for (int b = 0; b < burst && n < 1500; b++, n++)
            random_item((n / 250) % 2);
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 300)) @(negedge clock);
         end
         if (n % 500 == 0) begin
            while (board.answer_q.size() != 0) @(negedge clock);
         end
      end
      for (int t = 0; t < 2000 && board.answer_q.size() != 0; t++) @(negedge clock);
      repeat (300) @(negedge clock);
      if (board.mismatches == 0 && board.answer_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/drse_pkg.sv
hw/rtl/drse_table.sv
hw/rtl/disjoint_range_set_engine.sv
verif/testbench.sv
